FILE: rtl/bvs_pkg.sv
// Package holding the request codes, status codes and memory control type of the vector store.
`timescale 1ns / 1ps
`default_nettype none

package bvs_pkg;

    localparam int unsigned REQ_TYPE_W = 3;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned STATUS_W   = 2;

    localparam logic [REQ_TYPE_W-1:0] REQ_PUSH  = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_POP   = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_ERASE = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_a_en;
        logic rd_b_en;
    } bvs_mem_en_t;

endpackage : bvs_pkg

`default_nettype wire

FILE: rtl/bvs_req_if.sv
// Interfaces carrying requests into and results out of the vector store.
`timescale 1ns / 1ps
`default_nettype none

interface bvs_req_if
    import bvs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [INDEX_W-1:0]      index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output index, output value, input ready);
    modport sink   (input valid, input req_type, input index, input value, output ready);
endinterface : bvs_req_if

interface bvs_rsp_if
    import bvs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output read_value, output front_value, output back_value,
                    output count, output status, input ready);
    modport sink   (input valid, input read_value, input front_value, input back_value,
                    input count, input status, output ready);
endinterface : bvs_rsp_if

`default_nettype wire

FILE: rtl/bvs_mem.sv
// Entry storage: one write port and two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bvs_mem
    import bvs_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic              clk,
    input  wire bvs_mem_en_t       en,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]     addr_a,
    input  wire logic [AW-1:0]     addr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (en.rd_a_en)
        begin
            rdata_a <= mem[addr_a];
        end
        if (en.rd_b_en)
        begin
            rdata_b <= mem[addr_b];
        end
    end

endmodule : bvs_mem

`default_nettype wire

FILE: rtl/bounded_vector_store.sv
// Push, pop, read, clear and rejected requests pass through the fetch and result states after
// acceptance; an erase at position p in a list of c entries first shifts c-1-p entries down,
// each with a shift-read and then a shift-write step. One request is handled at a time; the next
// is taken once the sequencer is back in idle, which it enters as the previous result is
// registered. A result still waiting to be taken holds the following request in its last step.
// Reset clears the fill count, the sequencer and the result valid; entries keep their contents.
`timescale 1ns / 1ps
`default_nettype none

module bounded_vector_store
    import bvs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bvs_req_if.sink   req,
    bvs_rsp_if.source rsp
);

    // Address width for the entries and count width that can hold DEPTH itself.
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    // Comparisons of the request index against the count are done at this width so that
    // neither side is truncated.
    localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SH_RD  = 3'd1;
    localparam logic [2:0] S_SH_WR  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                rd_cap_reg, rd_cap_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   rdval_reg, rdval_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0]   rsp_read_reg, rsp_read_next;
    logic [DATA_W-1:0]   rsp_front_reg, rsp_front_next;
    logic [DATA_W-1:0]   rsp_back_reg, rsp_back_next;
    logic [COUNT_W-1:0]  rsp_count_reg, rsp_count_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;

    bvs_mem_en_t       mem_en;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_addr_a;
    logic [AW-1:0]     mem_addr_b;
    logic [DATA_W-1:0] mem_rdata_a;
    logic [DATA_W-1:0] mem_rdata_b;

    logic [CMPW-1:0]   idx_cmp;
    logic [CMPW-1:0]   count_cmp;
    logic [CW-1:0]     ptr_inc;
    logic [CW-1:0]     count_dec;
    logic              accept;
    logic              rsp_free;

    bvs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .en      (mem_en),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .addr_a  (mem_addr_a),
        .addr_b  (mem_addr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // A new request is taken only when the sequencer is idle; the result register is separate,
    // so an unclaimed result does not hold off taking the next request, only that request's result step.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign idx_cmp   = CMPW'(req.index);
    assign count_cmp = CMPW'(count_reg);
    assign ptr_inc   = ptr_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        rd_cap_next     = rd_cap_reg;
        status_next     = status_reg;
        rdval_next      = rdval_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_read_next   = rsp_read_reg;
        rsp_front_next  = rsp_front_reg;
        rsp_back_next   = rsp_back_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_status_next = rsp_status_reg;

        mem_en     = '0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = req.value;
        mem_addr_a = AW'(req.index);
        mem_addr_b = '0;

        // The result register empties once the consumer takes it.
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    rd_cap_next = 1'b0;
                    rdval_next  = '0;
                    state_next  = S_FETCH;
                    case (req.req_type)
                        REQ_PUSH:
                        begin
                            if (count_reg < DEPTH_C)
                            begin
                                mem_en.wr_en = 1'b1;
                                count_next   = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_dec;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        REQ_ERASE:
                        begin
                            if (idx_cmp < count_cmp)
                            begin
                                // The count drops now; the shift then runs while the pointer
                                // stays below the new count.
                                count_next = count_dec;
                                ptr_next   = CW'(req.index);
                                if (idx_cmp < CMPW'(count_dec))
                                begin
                                    state_next = S_SH_RD;
                                end
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        REQ_READ:
                        begin
                            if (idx_cmp < count_cmp)
                            begin
                                mem_en.rd_a_en = 1'b1;
                                rd_cap_next    = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // Unused request codes change nothing and report success.
                        end
                    endcase
                end
            end
            S_SH_RD:
            begin
                mem_en.rd_a_en = 1'b1;
                mem_addr_a     = ptr_inc[AW-1:0];
                state_next     = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_en.wr_en = 1'b1;
                mem_waddr    = ptr_reg[AW-1:0];
                mem_wdata    = mem_rdata_a;
                ptr_next     = ptr_inc;
                if (ptr_inc < count_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // Port A still holds the entry fetched for a read request; capture it before
                // both ports are reused for the first and last entries.
                if (rd_cap_reg)
                begin
                    rdval_next = mem_rdata_a;
                end
                mem_en.rd_a_en = 1'b1;
                mem_en.rd_b_en = 1'b1;
                mem_addr_a     = '0;
                mem_addr_b     = (count_reg != '0) ? count_dec[AW-1:0] : '0;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_read_next   = rdval_reg;
                    rsp_front_next  = (count_reg != '0) ? mem_rdata_a : '0;
                    rsp_back_next   = (count_reg != '0) ? mem_rdata_b : '0;
                    rsp_count_next  = COUNT_W'(count_reg);
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_cap_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cap_reg    <= rd_cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        status_reg     <= status_next;
        rdval_reg      <= rdval_next;
        rsp_read_reg   <= rsp_read_next;
        rsp_front_reg  <= rsp_front_next;
        rsp_back_reg   <= rsp_back_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = rsp_read_reg;
    assign rsp.front_value = rsp_front_reg;
    assign rsp.back_value  = rsp_back_reg;
    assign rsp.count       = rsp_count_reg;
    assign rsp.status      = rsp_status_reg;

endmodule : bounded_vector_store

`default_nettype wire

FILE: rtl/bvs_checker.sv
// Port-level checks on the vector store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bvs_checker
    import bvs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [DATA_W-1:0]   rsp_front_value,
    input wire logic [DATA_W-1:0]   rsp_back_value,
    input wire logic [COUNT_W-1:0]  rsp_count,
    input wire logic [STATUS_W-1:0] rsp_status
);

    // A result is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    // Only one request is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted while one is in progress");

    // An empty list reports zero for its first and last entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_count == '0) |-> (rsp_front_value == '0) && (rsp_back_value == '0))
        else $error("empty list reports a non-zero end value");

    // A rejected push leaves a full list behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL) |-> (rsp_count == COUNT_W'(DEPTH)))
        else $error("full status with a list that is not full");

    // A pop on an empty list leaves it empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_count == '0))
        else $error("empty status with live entries");

endmodule : bvs_checker

bind bounded_vector_store bvs_checker #(
    .DEPTH (DEPTH)
) u_bvs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_front_value (rsp.front_value),
    .rsp_back_value  (rsp.back_value),
    .rsp_count       (rsp.count),
    .rsp_status      (rsp.status)
);

`default_nettype wire
